### rtl/core/kfc_pkg.sv
// ----------------------------------------------------------------------------
// kfc_pkg
// shared constants, the datapath control struct and address helpers
// ----------------------------------------------------------------------------
package kfc_pkg;

	localparam int MAX_RADIUS_A = 3;
	localparam int MAX_RADIUS_B = 3;

	localparam int SIDE_A  = 2 * MAX_RADIUS_A + 1;
	localparam int SIDE_B  = 2 * MAX_RADIUS_B + 1;
	localparam int DEPTH_A = SIDE_A * SIDE_A;
	localparam int DEPTH_B = SIDE_B * SIDE_B;
	localparam int AW_A    = (DEPTH_A > 1) ? $clog2(DEPTH_A) : 1;
	localparam int AW_B    = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;

	// coordinate arithmetic: holds col - tap for any legal radius
	localparam int CW = 6;

	localparam int COEF_W = 16;
	localparam int PROD_W = 2 * COEF_W;
	localparam int ACC_W  = 40;

	// control from the sequencer to the memory and mac datapath
	typedef struct packed {
		logic                     wr_a;
		logic                     wr_b;
		logic [AW_A-1:0]          wr_addr_a;
		logic [AW_B-1:0]          wr_addr_b;
		logic signed [COEF_W-1:0] wr_data;
		logic                     tap_en;
		logic                     tap_ok;
		logic [AW_A-1:0]          a_addr;
		logic [AW_B-1:0]          b_addr;
		logic                     acc_clr;
	} kfc_op_t;

	function automatic logic signed [CW-1:0] sabs(input logic signed [CW-1:0] v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic logic [AW_A-1:0] addr_a(input logic signed [CW-1:0] c,
		input logic signed [CW-1:0] r);
		int idx;
		idx = (int'(r) + MAX_RADIUS_A) * SIDE_A + int'(c) + MAX_RADIUS_A;
		return AW_A'(idx);
	endfunction

	function automatic logic [AW_B-1:0] addr_b(input logic signed [CW-1:0] c,
		input logic signed [CW-1:0] r);
		int idx;
		idx = (int'(r) + MAX_RADIUS_B) * SIDE_B + int'(c) + MAX_RADIUS_B;
		return AW_B'(idx);
	endfunction

endpackage

### rtl/core/kfc_mac.sv
// ----------------------------------------------------------------------------
// kfc_mac
// kernel a and b memories, registered multiply and 40-bit accumulator
// ----------------------------------------------------------------------------
module kfc_mac
	import kfc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  kfc_op_t                 op,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [COEF_W-1:0] mem_a [DEPTH_A];
	logic signed [COEF_W-1:0] mem_b [DEPTH_B];

	logic signed [COEF_W-1:0] a_rd_s1;
	logic signed [COEF_W-1:0] b_rd_s1;
	logic                     ok_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     ok_s2;
	logic signed [ACC_W-1:0]  acc_q;

	// loads and tap reads never share a cycle, so no forwarding is needed
	always_ff @(posedge clk) begin
		if (op.wr_a) begin
			mem_a[op.wr_addr_a] <= op.wr_data;
		end
		if (op.wr_b) begin
			mem_b[op.wr_addr_b] <= op.wr_data;
		end
		if (op.tap_en) begin
			a_rd_s1 <= mem_a[op.a_addr];
			b_rd_s1 <= mem_b[op.b_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_s1 <= 1'b0;
			ok_s2 <= 1'b0;
		end else begin
			ok_s1 <= op.tap_en & op.tap_ok;
			ok_s2 <= ok_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_rd_s1 * b_rd_s1;
		if (op.acc_clr) begin
			acc_q <= '0;
		end else if (ok_s2) begin
			acc_q <= acc_q + {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
	end

	assign acc = acc_q;

endmodule

### rtl/core/kernel_full_convolution.sv
// ----------------------------------------------------------------------------
// kernel_full_convolution
// full 2-d convolution of two square kernels held in on-chip memories
// ----------------------------------------------------------------------------
//
// channel   | dir | handshake           | payload
// ----------+-----+---------------------+--------------------------------------
// s_axis    | in  | s_tvalid / s_tready | s_tuser mode, s_tdata col,row,coef
// m_axis    | out | m_tvalid / m_tready | m_tdata result_value, m_tuser pos ok
// cfg       | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (radius a / b)
//
// a load item writes one memory entry when it lies inside that kernel's radius
// a read item inside the combined radius does one multiply-accumulate per tap
//   of b, one read port per memory, then lets the memory read, product and
//   accumulate stages drain
// a read item outside the combined radius skips the taps and returns zero
// the result sits in an output register; the next item is taken while it waits
// reset clears control state and sets both radii to 1; memories are not cleared
module kernel_full_convolution
	import kfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [3:0] col, [7:4] row, [23:8] coef
	input  logic [1:0]  s_tuser,   // [1:0] mode
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [39:0] result_value
	output logic        m_tuser,   // [0] position_ok
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_data
);

	// item modes
	localparam logic [1:0] MODE_LOAD_A = 2'd0;
	localparam logic [1:0] MODE_LOAD_B = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;

	// register indexes
	localparam logic REG_RADIUS_A = 1'b0;
	localparam logic REG_RADIUS_B = 1'b1;

	// sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	// drain step at which the accumulator is final after the last tap is issued
	localparam logic [1:0] DRAIN_LAST = 2'd2;

	logic [1:0] state_q;
	logic [1:0] drain_q;
	logic [1:0] radius_a_q;
	logic [1:0] radius_b_q;

	// tap counters and the latched read position
	logic signed [CW-1:0] x_q;
	logic signed [CW-1:0] y_q;
	logic signed [CW-1:0] col_q;
	logic signed [CW-1:0] row_q;
	logic                 pos_ok_q;

	logic                 out_valid_q;
	logic [ACC_W-1:0]     out_value_q;
	logic                 out_ok_q;

	logic signed [3:0]    in_col;
	logic signed [3:0]    in_row;
	logic signed [CW-1:0] col_x;
	logic signed [CW-1:0] row_x;
	logic [1:0]           in_mode;
	logic signed [CW-1:0] ra_raw;
	logic signed [CW-1:0] rb_raw;
	logic signed [CW-1:0] ra_eff;
	logic signed [CW-1:0] rb_eff;
	logic signed [CW-1:0] rc;
	logic                 in_acc;
	logic                 in_rng_a;
	logic                 in_rng_b;
	logic                 in_rng_c;
	logic signed [CW-1:0] ax;
	logic signed [CW-1:0] ay;
	logic                 tap_ok;
	logic                 tap_last;
	logic                 out_free;
	logic                 out_load;
	logic signed [ACC_W-1:0] acc;
	kfc_op_t              op;

	assign in_col  = s_tdata[3:0];
	assign in_row  = s_tdata[7:4];
	assign in_mode = s_tuser;
	assign col_x   = CW'(in_col);
	assign row_x   = CW'(in_row);

	// radius registers saturate at the memory size
	assign ra_raw = signed'({{(CW-2){1'b0}}, radius_a_q});
	assign rb_raw = signed'({{(CW-2){1'b0}}, radius_b_q});
	assign ra_eff = (ra_raw > CW'(MAX_RADIUS_A)) ? CW'(MAX_RADIUS_A) : ra_raw;
	assign rb_eff = (rb_raw > CW'(MAX_RADIUS_B)) ? CW'(MAX_RADIUS_B) : rb_raw;
	assign rc     = ra_eff + rb_eff;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid & s_tready;

	assign in_rng_a = (sabs(col_x) <= ra_eff) && (sabs(row_x) <= ra_eff);
	assign in_rng_b = (sabs(col_x) <= rb_eff) && (sabs(row_x) <= rb_eff);
	assign in_rng_c = (sabs(col_x) <= rc) && (sabs(row_x) <= rc);

	// a tap only counts where the matching a entry lies inside radius a
	assign ax       = col_q - x_q;
	assign ay       = row_q - y_q;
	assign tap_ok   = (sabs(ax) <= ra_eff) && (sabs(ay) <= ra_eff);
	assign tap_last = (x_q == rb_eff) && (y_q == rb_eff);

	always_comb begin
		op           = '0;
		op.wr_data   = s_tdata[23:8];
		op.wr_addr_a = addr_a(col_x, row_x);
		op.wr_addr_b = addr_b(col_x, row_x);
		op.wr_a      = in_acc && (in_mode == MODE_LOAD_A) && in_rng_a;
		op.wr_b      = in_acc && (in_mode == MODE_LOAD_B) && in_rng_b;
		op.acc_clr   = in_acc && (in_mode == MODE_READ);
		op.tap_en    = (state_q == ST_RUN);
		op.tap_ok    = tap_ok;
		// out-of-range taps read a harmless entry; the product is dropped
		op.a_addr    = tap_ok ? addr_a(ax, ay) : '0;
		op.b_addr    = addr_b(x_q, y_q);
	end

	kfc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.acc    (acc)
	);

	// output register
	assign out_free = !out_valid_q || m_tready;
	assign out_load = (state_q == ST_DRAIN) && (drain_q == DRAIN_LAST) && out_free;

	// sequencer: one tap of b per cycle, rows of b innermost
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			drain_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (in_mode == MODE_READ)) begin
						if (in_rng_c) begin
							state_q <= ST_RUN;
						end else begin
							// nothing to sum, accumulator is already cleared
							state_q <= ST_DRAIN;
							drain_q <= DRAIN_LAST;
						end
					end
				end
				ST_RUN: begin
					if (tap_last) begin
						state_q <= ST_DRAIN;
						drain_q <= '0;
					end
				end
				ST_DRAIN: begin
					if (drain_q != DRAIN_LAST) begin
						drain_q <= drain_q + 2'd1;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// tap counters and latched position
	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_q    <= col_x;
			row_q    <= row_x;
			pos_ok_q <= in_rng_c;
			x_q      <= -rb_eff;
			y_q      <= -rb_eff;
		end else if (state_q == ST_RUN) begin
			if (y_q == rb_eff) begin
				y_q <= -rb_eff;
				x_q <= x_q + CW'(1);
			end else begin
				y_q <= y_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= acc;
			out_ok_q    <= pos_ok_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = out_ok_q;

	// configuration registers, written only while idle
	assign cfg_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_a_q <= 2'd1;
			radius_b_q <= 2'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RADIUS_A: radius_a_q <= cfg_data;
				REG_RADIUS_B: radius_b_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

### bench/kfc_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kfc_result_checker
// watches the item, result and register channels of the kernel convolver,
// keeps its own copy of both kernels and the radii, and checks every result
// against the full convolution it works out for the read position
// ----------------------------------------------------------------------------
package kfc_tb_pkg;

	typedef enum logic [1:0] {
		MODE_LOAD_A = 2'd0,
		MODE_LOAD_B = 2'd1,
		MODE_READ   = 2'd2,
		MODE_SPARE  = 2'd3
	} kfc_mode_t;

	typedef enum logic {
		REG_RADIUS_A = 1'b0,
		REG_RADIUS_B = 1'b1
	} kfc_reg_t;

	typedef struct packed {
		logic signed [39:0] value;
		logic               pos_ok;
	} kfc_result_t;

endpackage

module kfc_result_checker
	import kfc_pkg::*;
	import kfc_tb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_data,
	output int          mismatch_count,
	output int          reads_in_flight,
	output int          results_checked
);

	logic signed [COEF_W-1:0] kern_a [DEPTH_A];
	logic signed [COEF_W-1:0] kern_b [DEPTH_B];
	int                       radius_a_set;
	int                       radius_b_set;
	kfc_result_t              pending_sums [$];

	function automatic int mag(input int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic int clamp_radius(input int r, input int max_r);
		return (r > max_r) ? max_r : r;
	endfunction

	// full convolution at one position of the combined kernel
	function automatic kfc_result_t combined_coef_at(input int col, input int row);
		int                       ra;
		int                       rb;
		int                       rc;
		int                       tx;
		int                       ty;
		int                       ax;
		int                       ay;
		logic signed [ACC_W-1:0]  sum;
		kfc_result_t              res;
		ra = clamp_radius(radius_a_set, MAX_RADIUS_A);
		rb = clamp_radius(radius_b_set, MAX_RADIUS_B);
		rc = ra + rb;
		res.value  = '0;
		res.pos_ok = 1'b0;
		if (mag(col) > rc || mag(row) > rc)
			return res;
		sum = '0;
		for (tx = -rb; tx <= rb; tx++) begin
			for (ty = -rb; ty <= rb; ty++) begin
				ax = col - tx;
				ay = row - ty;
				if (mag(ax) <= ra && mag(ay) <= ra)
					sum += kern_a[(ay + MAX_RADIUS_A) * SIDE_A + ax + MAX_RADIUS_A] *
						kern_b[(ty + MAX_RADIUS_B) * SIDE_B + tx + MAX_RADIUS_B];
			end
		end
		res.value  = sum;
		res.pos_ok = 1'b1;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch_channels
		kfc_result_t want;
		int          col;
		int          row;
		int          ra;
		int          rb;
		if (!arst_n) begin
			radius_a_set    = 1;
			radius_b_set    = 1;
			mismatch_count  = 0;
			results_checked = 0;
			reads_in_flight = 0;
			pending_sums.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				results_checked++;
				if (pending_sums.size() == 0) begin
					$error("result item with no read waiting: result_value %0d position_ok %0b",
						$signed(m_tdata), m_tuser);
					mismatch_count++;
				end else begin
					want = pending_sums.pop_front();
					if (m_tdata !== want.value) begin
						$error("result_value: expected %0d, got %0d", want.value,
							$signed(m_tdata));
						mismatch_count++;
					end
					if (m_tuser !== want.pos_ok) begin
						$error("position_ok: expected %0b, got %0b", want.pos_ok, m_tuser);
						mismatch_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				col = int'($signed(s_tdata[3:0]));
				row = int'($signed(s_tdata[7:4]));
				ra  = clamp_radius(radius_a_set, MAX_RADIUS_A);
				rb  = clamp_radius(radius_b_set, MAX_RADIUS_B);
				case (kfc_mode_t'(s_tuser))
					MODE_LOAD_A: begin
						if (mag(col) <= ra && mag(row) <= ra)
							kern_a[(row + MAX_RADIUS_A) * SIDE_A + col + MAX_RADIUS_A] =
								s_tdata[23:8];
					end
					MODE_LOAD_B: begin
						if (mag(col) <= rb && mag(row) <= rb)
							kern_b[(row + MAX_RADIUS_B) * SIDE_B + col + MAX_RADIUS_B] =
								s_tdata[23:8];
					end
					MODE_READ: pending_sums.push_back(combined_coef_at(col, row));
					default: ;
				endcase
			end
			if (cfg_valid && cfg_ready) begin
				case (kfc_reg_t'(cfg_index))
					REG_RADIUS_A: radius_a_set = int'(cfg_data);
					REG_RADIUS_B: radius_b_set = int'(cfg_data);
					default: ;
				endcase
			end
			reads_in_flight = pending_sums.size();
		end
	end

endmodule

### bench/tb_kernel_full_convolution.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kernel_full_convolution
// drives load and read items into the kernel convolver under bursty input and
// a stalling output, steps the two radii through their extremes between
// phases, and leaves result checking to kfc_result_checker
// ----------------------------------------------------------------------------
module tb_kernel_full_convolution;
	import kfc_pkg::*;
	import kfc_tb_pkg::*;

	localparam int ITEM_TARGET  = 650;
	localparam int PHASE_ITEMS  = 70;
	// slowest read: one mac per tap of b at full radius plus the pipeline drain
	localparam int READ_LATENCY = SIDE_B * SIDE_B + 4;
	localparam int DRAIN_CYCLES = READ_LATENCY + 8;
	localparam int HOLD_CYCLES  = 800;
	localparam int STALL_LIMIT  = 4000;

	typedef enum int {
		READY_ALWAYS,
		READY_COIN,
		READY_ONE_IN_FOUR,
		READY_MOSTLY
	} ready_style_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [1:0]  cfg_data  = '0;

	int mismatch_count;
	int reads_in_flight;
	int results_checked;

	// stimulus side bookkeeping: which entries hold a coefficient, and the radii in force
	bit a_loaded [DEPTH_A];
	bit b_loaded [DEPTH_B];
	int radius_a_now   = 1;
	int radius_b_now   = 1;
	int burst_left     = 0;
	bit sender_calm    = 1'b0;
	bit hold_off_req   = 1'b0;
	int items_sent     = 0;
	int reads_sent     = 0;
	int settings_used  = 1;

	kernel_full_convolution DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	kfc_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.reads_in_flight (reads_in_flight),
		.results_checked (results_checked)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int mag(input int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic int span_pick(input int r);
		int v;
		v = $urandom_range(0, 2 * r);
		return v - r;
	endfunction

	// mostly full-range coefficients, with the two extremes and values near zero mixed in
	function automatic int pick_coef();
		case ($urandom_range(0, 9))
			0: return -32768;
			1: return 32767;
			2: return int'($urandom_range(0, 64)) - 32;
			default: return int'($signed(16'($urandom)));
		endcase
	endfunction

	// offer one item; a new burst may open with a gap on tvalid first
	task automatic push_item(input kfc_mode_t mode, input int col, input int row,
		input int coef);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = sender_calm ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {16'(coef), 4'(row), 4'(col)};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		items_sent++;
		// loads that fall outside the radius and the spare mode do no work
		case (mode)
			MODE_LOAD_A: begin
				if (mag(col) <= radius_a_now && mag(row) <= radius_a_now)
					a_loaded[(row + MAX_RADIUS_A) * SIDE_A + col + MAX_RADIUS_A] = 1'b1;
			end
			MODE_LOAD_B: begin
				if (mag(col) <= radius_b_now && mag(row) <= radius_b_now)
					b_loaded[(row + MAX_RADIUS_B) * SIDE_B + col + MAX_RADIUS_B] = 1'b1;
			end
			MODE_READ: begin
				reads_sent++;
			end
			default: ;
		endcase
	endtask

	// drop tvalid, wait for every read to come back, then let trailing loads retire
	task automatic settle_block();
		s_tvalid <= 1'b0;
		while (reads_in_flight != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// leaves cfg_valid high so that back-to-back writes never lower and raise it in one step
	task automatic write_reg(input kfc_reg_t idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= 2'(value);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_radii(input int ra, input int rb);
		write_reg(REG_RADIUS_A, ra);
		write_reg(REG_RADIUS_B, rb);
		cfg_valid <= 1'b0;
		radius_a_now = (ra > MAX_RADIUS_A) ? MAX_RADIUS_A : ra;
		radius_b_now = (rb > MAX_RADIUS_B) ? MAX_RADIUS_B : rb;
		settings_used++;
	endtask

	// write every entry inside the current radii that has never been written,
	// so that no read ever touches an undefined coefficient
	task automatic load_missing();
		int c;
		int r;
		for (r = -radius_a_now; r <= radius_a_now; r++)
			for (c = -radius_a_now; c <= radius_a_now; c++)
				if (!a_loaded[(r + MAX_RADIUS_A) * SIDE_A + c + MAX_RADIUS_A])
					push_item(MODE_LOAD_A, c, r, pick_coef());
		for (r = -radius_b_now; r <= radius_b_now; r++)
			for (c = -radius_b_now; c <= radius_b_now; c++)
				if (!b_loaded[(r + MAX_RADIUS_B) * SIDE_B + c + MAX_RADIUS_B])
					push_item(MODE_LOAD_B, c, r, pick_coef());
	endtask

	// one random item once both kernels are fully loaded: mostly reads and
	// in-radius reloads, with some out-of-range loads and reads and spare-mode noise
	task automatic random_item();
		int pick;
		int rc;
		int ra;
		int rb;
		pick = $urandom_range(0, 99);
		ra   = radius_a_now;
		rb   = radius_b_now;
		rc   = ra + rb;
		if (pick < 45)
			push_item(MODE_READ, span_pick(rc), span_pick(rc), pick_coef());
		else if (pick < 55)
			push_item(MODE_READ, span_pick(6), span_pick(6), pick_coef());
		else if (pick < 70)
			push_item(MODE_LOAD_A, span_pick(ra), span_pick(ra), pick_coef());
		else if (pick < 85)
			push_item(MODE_LOAD_B, span_pick(rb), span_pick(rb), pick_coef());
		else if (pick < 95)
			push_item(($urandom_range(0, 1) == 1) ? MODE_LOAD_B : MODE_LOAD_A,
				span_pick(6), span_pick(6), pick_coef());
		else
			push_item(MODE_SPARE, span_pick(6), span_pick(6), pick_coef());
	endtask

	// receiver: changing ready patterns, plus one long hold-off on request
	initial begin : result_sink
		ready_style_t style;
		int           style_left;
		int           tick;
		style      = READY_ALWAYS;
		style_left = 0;
		tick       = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_off_req = 1'b0;
			end else begin
				if (style_left == 0) begin
					style      = ready_style_t'($urandom_range(0, 3));
					style_left = $urandom_range(20, 120);
				end
				style_left--;
				tick++;
				case (style)
					READY_ALWAYS:      m_tready <= 1'b1;
					READY_COIN:        m_tready <= ($urandom_range(0, 1) == 1);
					READY_ONE_IN_FOUR: m_tready <= (tick % 4 == 0);
					default:           m_tready <= ($urandom_range(0, 6) != 0);
				endcase
			end
		end
	end

	// watchdog: any handshake on any channel counts as progress
	initial begin : stall_watch
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
				$display("kernel_full_convolution test failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int phase_ra [6];
		int phase_rb [6];
		int p;
		int c;
		int r;
		int k;
		phase_ra = '{3, 0, 0, 3, 2, 1};
		phase_rb = '{3, 0, 3, 0, 1, 2};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part at the reset radii of one: extreme coefficients in both kernels
		for (r = -1; r <= 1; r++)
			for (c = -1; c <= 1; c++)
				push_item(MODE_LOAD_A, c, r, (c == 0 && r == 0) ? 32767 : -32768);
		for (r = -1; r <= 1; r++)
			for (c = -1; c <= 1; c++)
				push_item(MODE_LOAD_B, c, r, (c == 1 && r == 1) ? 0 :
					(((c + r) % 2 == 0) ? -32768 : 32767));
		// centre, corners of the combined radius, just outside it, and two far positions
		push_item(MODE_READ, 0, 0, 0);
		push_item(MODE_READ, 2, 2, -1);
		push_item(MODE_READ, -2, -2, 32767);
		push_item(MODE_READ, -2, 2, -32768);
		push_item(MODE_READ, 3, 0, 0);
		push_item(MODE_READ, -6, 6, 0);
		push_item(MODE_READ, 6, -6, 0);
		// spare mode and loads outside the radius must leave no trace
		push_item(MODE_SPARE, 0, 0, 12345);
		push_item(MODE_LOAD_A, 2, 0, 32767);
		push_item(MODE_LOAD_B, -6, -6, -32768);
		push_item(MODE_READ, 1, -1, 0);
		settle_block();

		// fixed radius settings first, extremes included, then random ones
		for (p = 0; p < 6 || items_sent < ITEM_TARGET; p++) begin
			if (p < 6)
				set_radii(phase_ra[p], phase_rb[p]);
			else
				set_radii($urandom_range(0, 3), $urandom_range(0, 3));
			sender_calm = ($urandom_range(0, 3) == 0);
			load_missing();
			// with both radii at full size the reads are slow; stall the output
			// long enough that the result register and the input back up
			if (p == 0)
				hold_off_req = 1'b1;
			for (k = 0; k < PHASE_ITEMS; k++)
				random_item();
			settle_block();
		end

		$display("covered %0d items, %0d of them reads, over %0d radius settings",
			items_sent, reads_sent, settings_used);
		$display("checked %0d results, including a %0d-cycle output hold-off at full radii",
			results_checked, HOLD_CYCLES);
		if (mismatch_count == 0)
			$display("kernel_full_convolution test passed");
		else
			$display("kernel_full_convolution test failed");
		$finish;
	end

endmodule
